// File: hdl/lpfr_pkg.sv
// Package: shared constants, types and register indexes of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package lpfr_pkg;

    // Length prefix: number of bytes, least significant first
    localparam int LEN_BYTES = 8;
    localparam int LEN_CNT_W = $clog2(LEN_BYTES + 1);
    localparam int POS_W     = (LEN_BYTES > 1) ? $clog2(LEN_BYTES) : 1;
    localparam int REM_W     = 8 * LEN_BYTES;

    // Result kinds
    localparam logic KIND_REPLY   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NACK  = 2'd2;

    // Configuration reset values
    localparam logic [7:0] START_RESET = 8'd1;
    localparam logic [7:0] ACK_RESET   = 8'd6;
    localparam logic [7:0] NACK_RESET  = 8'd21;

    // Result queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One result item
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       frame_end;
    } lpfr_item_t;

    // Push request from the front into the queue
    typedef struct packed {
        logic       valid;
        lpfr_item_t item;
    } lpfr_push_t;

    // Queue occupancy status
    typedef struct packed {
        logic full;
        logic empty;
    } lpfr_qstat_t;

endpackage

`default_nettype wire

// File: hdl/lpfr_front.sv
// Front part: accepts link bytes, tracks the frame phase and builds result items.
`timescale 1ns / 1ps
`default_nettype none

module lpfr_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lpfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire lpfr_pkg::lpfr_qstat_t         qstat,
    output lpfr_pkg::lpfr_push_t               push
);
    import lpfr_pkg::*;

    // Phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic [LEN_CNT_W-1:0] len_left_reg, len_left_next;
    logic [REM_W-1:0]     remaining_reg, remaining_next;
    logic [7:0]           start_code_reg, ack_code_reg, nack_code_reg;

    logic                 accept;
    logic [POS_W-1:0]     pos;
    logic [REM_W-1:0]     rem_or;
    logic                 last;
    lpfr_item_t           item;
    logic                 produce;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= START_RESET;
            ack_code_reg   <= ACK_RESET;
            nack_code_reg  <= NACK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START: start_code_reg <= cfg_data;
                CFG_ACK:   ack_code_reg   <= cfg_data;
                CFG_NACK:  nack_code_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Stall only while the queue has no room
    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;

    // Byte position of the next length byte
    assign pos = POS_W'(LEN_CNT_W'(LEN_BYTES) - len_left_reg);

    always_comb
    begin
        rem_or = remaining_reg;
        rem_or[{pos, 3'b000} +: 8] = remaining_reg[{pos, 3'b000} +: 8] | data_byte;
    end

    assign last = (remaining_reg <= REM_W'(1));

    // Phase update and result item
    always_comb
    begin
        phase_next     = phase_reg;
        len_left_next  = len_left_reg;
        remaining_next = remaining_reg;
        item.kind      = KIND_REPLY;
        item.data      = nack_code_reg;
        item.frame_end = 1'b0;
        produce        = 1'b1;
        case (phase_reg)
            PH_LEN:
            begin
                produce        = 1'b0;
                remaining_next = rem_or;
                len_left_next  = len_left_reg - LEN_CNT_W'(1);
                if (len_left_next == '0)
                begin
                    phase_next = (rem_or == '0) ? PH_IDLE : PH_DATA;
                end
            end
            PH_DATA:
            begin
                item.kind      = KIND_PAYLOAD;
                item.data      = data_byte;
                item.frame_end = last;
                remaining_next = last ? '0 : remaining_reg - REM_W'(1);
                if (last)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                // Idle, and the unused phase code
                if (data_byte == start_code_reg)
                begin
                    phase_next     = PH_LEN;
                    len_left_next  = LEN_CNT_W'(LEN_BYTES);
                    remaining_next = '0;
                    item.data      = ack_code_reg;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    assign push.valid = accept && produce;
    assign push.item  = item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            len_left_reg  <= '0;
            remaining_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            len_left_reg  <= len_left_next;
            remaining_reg <= remaining_next;
        end
    end

    // Length bytes never give a result
    a_len_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_LEN) |-> !push.valid)
        else $error("result produced for a length byte");

    // The payload phase is only entered with bytes still to come
    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (remaining_reg != '0))
        else $error("payload phase with zero bytes remaining");

    // Length collection always has a byte outstanding
    a_len_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEN) |-> (len_left_reg != '0))
        else $error("length phase with no length bytes left");

endmodule

`default_nettype wire

// File: hdl/lpfr_queue.sv
// Short result queue between the front and the back of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

module lpfr_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lpfr_pkg::lpfr_push_t push,
    input  wire logic                 pop,
    output lpfr_pkg::lpfr_item_t      head,
    output lpfr_pkg::lpfr_qstat_t     qstat
);
    import lpfr_pkg::*;

    lpfr_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push.valid && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = entry_reg[rd_ptr_reg];

    // Pointer wrap and occupancy count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !qstat.full)
        else $error("push into a full queue");

    // Occupancy stays within the queue depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // Pointers agree with the count
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with differing pointers");

endmodule

`default_nettype wire

// File: hdl/lpfr_back.sv
// Back part: moves queued items into the output register and hands them out.
`timescale 1ns / 1ps
`default_nettype none

module lpfr_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lpfr_pkg::lpfr_qstat_t qstat,
    input  wire lpfr_pkg::lpfr_item_t  head,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       kind,
    output logic [7:0]                 out_byte,
    output logic                       frame_end
);
    import lpfr_pkg::*;

    logic       out_valid_reg, out_valid_next;
    lpfr_item_t out_item_reg;
    logic       load;

    // Refill whenever the output register is free or being taken
    assign load = !qstat.empty && (!out_valid_reg || !out_stall);
    assign pop  = load;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= head;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_item_reg.kind;
    assign out_byte  = out_item_reg.data;
    assign frame_end = out_item_reg.frame_end;

    // A waiting item is refilled into the register as soon as it drains
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (!qstat.empty && !out_valid_reg) |=> out_valid_reg)
        else $error("queued item not moved to output");

endmodule

`default_nettype wire

// File: hdl/length_prefixed_frame_receiver_unit.sv
// Top level: length-prefixed frame receiver, front, queue and back connected.
`timescale 1ns / 1ps
`default_nettype none

// Takes one link byte per cycle unless stalled. In idle each byte gets a
// reply item: the ack code if it matches the start code (opening a frame),
// otherwise the nack code. The next eight bytes form the payload length,
// least significant first, and give no item. Each following payload byte is
// passed out with kind set and frame_end on the last one; a zero length
// returns straight to idle. Sustained rate is one byte per cycle while the
// queue has room, set by the phase update in the front (one 64-bit decrement
// and compare). Results pass a queue entry, then the output register; a
// two-entry queue and the output register absorb output stalls, and the
// input stalls only when that queue is full. Codes are written through the
// configuration port (index 0 start, 1 ack, 2 nack) and are taken at once.
module length_prefixed_frame_receiver_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               kind,
    output logic [7:0]                         out_byte,
    output logic                               frame_end,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lpfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data
);
    import lpfr_pkg::*;

    lpfr_push_t  push;
    lpfr_qstat_t qstat;
    lpfr_item_t  head;
    logic        pop;

    lpfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .push      (push)
    );

    lpfr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    lpfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

endmodule

`default_nettype wire
